// ===== src/s2k_pkg.sv =====
package s2k_pkg;

  localparam int unsigned S2K_ROUNDS   = 35;
  localparam int unsigned S2K_WORD_W   = 32;
  localparam int unsigned S2K_SHIFT_W  = 5;
  localparam int unsigned S2K_CFG_IDX_W = 3;

  typedef logic [S2K_WORD_W-1:0]    word_t;
  typedef logic [S2K_SHIFT_W-1:0]   shamt_t;
  typedef logic [S2K_CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes on the config port
  localparam cfg_idx_t REG_TEST_MASK      = 3'd0;
  localparam cfg_idx_t REG_SHIFT_AMOUNT   = 3'd1;
  localparam cfg_idx_t REG_FEEDBACK_MASK  = 3'd2;
  localparam cfg_idx_t REG_UNLOCK_SEED    = 3'd3;
  localparam cfg_idx_t REG_UNDEFINED_SEED = 3'd4;
  localparam cfg_idx_t REG_UNLOCK_KEY     = 3'd5;

  // reset values of the config registers
  localparam word_t  RST_TEST_MASK      = 32'h8000_0000;
  localparam shamt_t RST_SHIFT_AMOUNT   = 5'd1;
  localparam word_t  RST_FEEDBACK_MASK  = 32'h0000_0000;
  localparam word_t  RST_UNLOCK_SEED    = 32'h0000_0000;
  localparam word_t  RST_UNDEFINED_SEED = 32'hFFFF_FFFF;
  localparam word_t  RST_UNLOCK_KEY     = 32'h0000_0000;

  // one shift/xor round
  function automatic word_t s2k_round(input word_t s, input word_t tmask,
                                      input shamt_t sh, input word_t fb);
    word_t shifted;
    shifted = s << sh;
    return ((s & tmask) != '0) ? (shifted ^ fb) : shifted;
  endfunction

endpackage

// ===== src/s2k_seed_if.sv =====
interface s2k_seed_if;
  import s2k_pkg::*;

  logic  valid;
  logic  ready;
  word_t seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

// ===== src/s2k_key_if.sv =====
interface s2k_key_if;
  import s2k_pkg::*;

  logic  valid;
  logic  ready;
  word_t key;
  logic  bypassed;

  modport source (output valid, output key, output bypassed, input ready);
  modport sink   (input valid, input key, input bypassed, output ready);
endinterface

// ===== src/seed_to_key_shift_xor_unit.sv =====
// Seed-to-key shift/xor unit. Each seed transfer on in_chan yields one key
// transfer on out_chan, in order. A seed equal to the unlock or undefined
// seed register returns unlock_key with bypassed set; any other seed runs
// ROUNDS rounds of (shift left by shift_amount, xor feedback_mask when
// seed & test_mask is nonzero). The pipeline holds one round per register
// stage after an input stage, and takes a new seed every cycle while the
// stages ahead can move. Each stage stalls only when it is full and the stage
// after it cannot take its item, so empty slots fill while a key waits on
// out_chan. Config registers are written through cfg_we/cfg_idx/cfg_wdata
// and must only change while no seed is in flight; indexes above five are
// ignored.
module seed_to_key_shift_xor_unit #(
  parameter int unsigned ROUNDS = s2k_pkg::S2K_ROUNDS
) (
  input  logic               clk,
  input  logic               rst_n,
  s2k_seed_if.sink           in_chan,
  s2k_key_if.source          out_chan,
  input  logic               cfg_we,
  input  s2k_pkg::cfg_idx_t  cfg_idx,
  input  s2k_pkg::word_t     cfg_wdata
);
  import s2k_pkg::*;

  // config registers
  word_t  test_mask_r;
  shamt_t shift_amount_r;
  word_t  feedback_mask_r;
  word_t  unlock_seed_r;
  word_t  undefined_seed_r;
  word_t  unlock_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      test_mask_r      <= RST_TEST_MASK;
      shift_amount_r   <= RST_SHIFT_AMOUNT;
      feedback_mask_r  <= RST_FEEDBACK_MASK;
      unlock_seed_r    <= RST_UNLOCK_SEED;
      undefined_seed_r <= RST_UNDEFINED_SEED;
      unlock_key_r     <= RST_UNLOCK_KEY;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_TEST_MASK:      test_mask_r      <= cfg_wdata;
        REG_SHIFT_AMOUNT:   shift_amount_r   <= cfg_wdata[S2K_SHIFT_W-1:0];
        REG_FEEDBACK_MASK:  feedback_mask_r  <= cfg_wdata;
        REG_UNLOCK_SEED:    unlock_seed_r    <= cfg_wdata;
        REG_UNDEFINED_SEED: undefined_seed_r <= cfg_wdata;
        REG_UNLOCK_KEY:     unlock_key_r     <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Stage 0 registers the seed and its bypass flag; stage k holds the
  // value after k rounds. The last stage also applies the bypass mux, so
  // out_chan is driven straight from registers.
  logic  [ROUNDS:0] valid_r;
  logic  [ROUNDS:0] byp_r;
  word_t            data_r [ROUNDS+1];
  // adv[k]: stage k may load this cycle
  logic  [ROUNDS:0] adv;

  assign adv[ROUNDS] = !valid_r[ROUNDS] || out_chan.ready;

  genvar k;
  generate
    for (k = 0; k < ROUNDS; k++) begin : g_adv
      assign adv[k] = !valid_r[k] || adv[k+1];
    end
  endgenerate

  assign in_chan.ready = adv[0];

  // input stage: bypass compare
  logic byp_nxt;
  assign byp_nxt = (in_chan.seed == unlock_seed_r) || (in_chan.seed == undefined_seed_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (adv[0]) begin
      valid_r[0] <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && in_chan.valid) begin
      data_r[0] <= in_chan.seed;
      byp_r[0]  <= byp_nxt;
    end
  end

  // round stages
  generate
    for (k = 1; k <= ROUNDS; k++) begin : g_stage
      word_t data_nxt;

      always_comb begin
        data_nxt = s2k_round(data_r[k-1], test_mask_r, shift_amount_r, feedback_mask_r);
        if ((k == ROUNDS) && byp_r[k-1]) begin
          data_nxt = unlock_key_r;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          valid_r[k] <= 1'b0;
        end else if (adv[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end

      always_ff @(posedge clk) begin
        if (adv[k] && valid_r[k-1]) begin
          data_r[k] <= data_nxt;
          byp_r[k]  <= byp_r[k-1];
        end
      end
    end
  endgenerate

  assign out_chan.valid    = valid_r[ROUNDS];
  assign out_chan.key      = data_r[ROUNDS];
  assign out_chan.bypassed = byp_r[ROUNDS];

endmodule

// ===== src/s2k_checker.sv =====
module s2k_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_key,
  input logic        out_bypassed
);

  // seeds taken but not yet returned as keys
  logic [7:0] inflight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
    end
  end

  // a stalled key holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_bypassed))
    else $error("key changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result present right after reset");

  // free output slot means the pipeline can take a seed
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input stalled with output free");

  // every key offered belongs to a seed already taken
  a_no_orphan_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("key offered with no seed pending");

endmodule

bind seed_to_key_shift_xor_unit s2k_checker u_s2k_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_key      (out_chan.key),
  .out_bypassed (out_chan.bypassed)
);

// ===== test/s2k_tb_pkg.sv =====
package s2k_tb_pkg;
  import s2k_pkg::*;

  typedef struct packed {
    word_t key;
    logic  bypassed;
  } key_result_t;

  class key_scoreboard;
    int unsigned   rounds;
    word_t         test_mask;
    shamt_t        shift_amount;
    word_t         feedback_mask;
    word_t         unlock_seed;
    word_t         undefined_seed;
    word_t         unlock_key;
    key_result_t   pending_keys[$];
    int unsigned   errors;

    function new(int unsigned rounds);
      this.rounds    = rounds;
      test_mask      = RST_TEST_MASK;
      shift_amount   = RST_SHIFT_AMOUNT;
      feedback_mask  = RST_FEEDBACK_MASK;
      unlock_seed    = RST_UNLOCK_SEED;
      undefined_seed = RST_UNDEFINED_SEED;
      unlock_key     = RST_UNLOCK_KEY;
      errors         = 0;
    endfunction

    // mirror of a register write; spare indexes are dropped
    function void write_reg(cfg_idx_t idx, word_t data);
      case (idx)
        REG_TEST_MASK:      test_mask      = data;
        REG_SHIFT_AMOUNT:   shift_amount   = data[S2K_SHIFT_W-1:0];
        REG_FEEDBACK_MASK:  feedback_mask  = data;
        REG_UNLOCK_SEED:    unlock_seed    = data;
        REG_UNDEFINED_SEED: undefined_seed = data;
        REG_UNLOCK_KEY:     unlock_key     = data;
        default: ;
      endcase
    endfunction

    function key_result_t derive_key(word_t seed);
      key_result_t res;
      word_t       s;
      logic        hit;
      if (seed == unlock_seed || seed == undefined_seed) begin
        res.key      = unlock_key;
        res.bypassed = 1'b1;
      end else begin
        s = seed;
        for (int unsigned r = 0; r < rounds; r++) begin
          hit = |(s & test_mask);
          s   = s << shift_amount;
          if (hit) begin
            s = s ^ feedback_mask;
          end
        end
        res.key      = s;
        res.bypassed = 1'b0;
      end
      return res;
    endfunction

    function void note_seed(word_t seed);
      pending_keys.push_back(derive_key(seed));
    endfunction

    function void check_key(word_t key, logic bypassed, time stamp);
      key_result_t exp_res;
      if (pending_keys.size() == 0) begin
        $display("%0t unexpected key transfer: expected none, actual key %h bypassed %b",
                 stamp, key, bypassed);
        errors++;
        return;
      end
      exp_res = pending_keys.pop_front();
      if (key !== exp_res.key) begin
        $display("%0t key mismatch: expected %h, actual %h", stamp, exp_res.key, key);
        errors++;
      end
      if (bypassed !== exp_res.bypassed) begin
        $display("%0t bypassed mismatch: expected %b, actual %b",
                 stamp, exp_res.bypassed, bypassed);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== test/tb_seed_to_key_shift_xor_unit.sv =====
module tb_seed_to_key_shift_xor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import s2k_pkg::*;
  import s2k_tb_pkg::*;

  localparam int unsigned ROUNDS          = S2K_ROUNDS;
  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned SEEDS_PER_PHASE = 50;
  localparam int unsigned HOLD_CYCLES     = 160;  // well past the pipeline depth
  localparam int unsigned IDLE_PCT        = 21;

  // indexes past the last register; writes there must not land anywhere
  localparam cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  word_t    cfg_wdata;

  s2k_seed_if seed_ch();
  s2k_key_if  key_ch();

  key_scoreboard sb;

  bit idle_en;   // random idling on both channels
  bit hold_req;  // one-shot request for a long receiver hold-off

  seed_to_key_shift_xor_unit #(
    .ROUNDS(ROUNDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (seed_ch.sink),
    .out_chan (key_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Monitor: both channels sampled at the edge, before any NBA update lands.
  // Output is checked first; a seed taken this edge cannot have its key out yet.
  always @(posedge clk) begin
    if (rst_n) begin
      if (key_ch.valid && key_ch.ready) begin
        sb.check_key(key_ch.key, key_ch.bypassed, $time);
      end
      if (seed_ch.valid && seed_ch.ready) begin
        sb.note_seed(seed_ch.seed);
      end
    end
  end

  // Receiver: random ready, plus one long hold-off on request so the
  // pipeline fills and back-pressure reaches the seed channel.
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        key_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        key_ch.ready <= !(idle_en && ($urandom_range(99) < IDLE_PCT));
        @(posedge clk);
      end
    end
  end

  // Offer one seed, idling first at random; returns after the transfer edge.
  // valid is left high so back-to-back seeds need no second assignment.
  task automatic send_seed(input word_t seed);
    while (idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      seed_ch.valid <= 1'b0;
      seed_ch.seed  <= $urandom();
      @(posedge clk);
    end
    seed_ch.valid <= 1'b1;
    seed_ch.seed  <= seed;
    do @(posedge clk); while (!seed_ch.ready);
  endtask

  // Stop offering and wait until every expected key has come back.
  task automatic wait_drain();
    seed_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_keys.size() != 0) @(posedge clk);
  endtask

  // One register write; cfg_we is left high for back-to-back writes.
  task automatic cfg_write(input cfg_idx_t idx, input word_t data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input word_t tm, input word_t sh, input word_t fb,
                            input word_t us, input word_t uds, input word_t uk);
    cfg_write(REG_TEST_MASK, tm);
    cfg_write(REG_SHIFT_AMOUNT, sh);
    cfg_write(REG_FEEDBACK_MASK, fb);
    cfg_write(REG_UNLOCK_SEED, us);
    cfg_write(REG_UNDEFINED_SEED, uds);
    cfg_write(REG_UNLOCK_KEY, uk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed(input word_t seeds[$]);
    foreach (seeds[i]) begin
      send_seed(seeds[i]);
    end
    wait_drain();
  endtask

  // Main sequence
  initial begin
    word_t tm;
    word_t sh;
    word_t fb;
    word_t us;
    word_t uds;
    word_t uk;
    word_t seed;
    int unsigned pick;

    sb       = new(ROUNDS);
    idle_en  = 1'b1;
    hold_req = 1'b0;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_TEST_MASK;
    cfg_wdata     <= '0;
    seed_ch.valid <= 1'b0;
    seed_ch.seed  <= '0;
    key_ch.ready  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: 0 and all-ones are the two bypass seeds, the rest
    // go through plain shifting since feedback_mask is zero.
    run_directed('{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                   32'h7FFF_FFFF, 32'hAAAA_AAAA});

    // Both bypass seeds equal: a match on both still gives unlock_key.
    set_config(32'h8000_0000, 32'd1, 32'h04C1_1DB7, 32'h1234_5678, 32'h1234_5678,
               32'hDEAD_BEEF);
    run_directed('{32'h1234_5678, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0F0F_0F0F});

    // Zero shift: upper bits of the write are dropped, feedback hits every round.
    set_config(32'hFFFF_FFFF, 32'h0000_0020, 32'hA5A5_A5A5, 32'h0000_0000,
               32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_directed('{32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1357_9BDF});

    // Max shift from an all-ones write, test mask never hits; then writes
    // to the spare indexes, which must leave every register alone.
    set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'h0000_0000, 32'h0000_0000);
    @(posedge clk);
    cfg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_HI, 32'h5A5A_5A5A);
    cfg_we <= 1'b0;
    run_directed('{32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000});

    // Low-bit test mask with max shift and two-bit feedback.
    set_config(32'h0000_0001, 32'h0000_001F, 32'h8000_0001, 32'h0000_0000,
               32'hFFFF_FFFF, 32'h0000_0000);
    run_directed('{32'h0000_0001, 32'h0000_0002, 32'hFFFF_FFFE, 32'h7FFF_FFFF});

    // Random phases, each with a fresh configuration
    for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
      idle_en = !(phase == 4 || phase == 5);  // a long stretch with no idling

      case ($urandom_range(4))
        0:       tm = '0;
        1:       tm = '1;
        2:       tm = 32'h1 << $urandom_range(31);
        default: tm = $urandom();
      endcase
      case ($urandom_range(4))
        0:       sh = $urandom() & 32'hFFFF_FFE0;              // shift of zero
        1:       sh = $urandom() | 32'h0000_001F;              // shift of 31
        2:       sh = ($urandom() & 32'hFFFF_FFE0) | 32'd1;
        3:       sh = ($urandom() & 32'hFFFF_FFE0) | $urandom_range(3, 2);
        default: sh = $urandom();
      endcase
      case ($urandom_range(3))
        0:       fb = '0;
        1:       fb = '1;
        default: fb = $urandom();
      endcase
      us  = $urandom();
      uds = ($urandom_range(3) == 0) ? us : $urandom();
      uk  = $urandom();

      if (phase[0]) begin
        cfg_write(REG_SPARE_LO, $urandom());
        cfg_write(REG_SPARE_HI, $urandom());
      end
      set_config(tm, sh, fb, us, uds, uk);

      if (phase == 2) begin
        hold_req = 1'b1;
      end

      repeat (SEEDS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          seed = us;
        end else if (pick < 20) begin
          seed = uds;
        end else if (pick < 25) begin
          seed = '0;
        end else if (pick < 30) begin
          seed = '1;
        end else begin
          seed = $urandom();
        end
        send_seed(seed);
      end
      wait_drain();
    end

    // Quiet tail so a stray extra key transfer would still be caught
    repeat (ROUNDS + 8) @(posedge clk);
    if (sb.pending_keys.size() != 0) begin
      $display("%0t keys still pending: expected 0, actual %0d", $time,
               sb.pending_keys.size());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("%0t timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
